// File: rtl/tnc_pkg.sv
// Shared types, constants and codes of the tag nesting checker.
package tnc_pkg;

  // Sizing of the tag stack and of one tag name.
  localparam int STACK_DEPTH    = 64;
  localparam int MAX_NAME_CHARS = 8;
  localparam int NAME_W         = 8 * MAX_NAME_CHARS;
  localparam int LEN_W          = $clog2(MAX_NAME_CHARS + 1);
  localparam int DEPTH_W        = $clog2(STACK_DEPTH + 1);

  // Characters that steer the parser.
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_G     = 8'h67;

  typedef enum logic [2:0] {
    MODE_OUTSIDE  = 3'd0,
    MODE_AFTER_LT = 3'd1,
    MODE_OPEN     = 3'd2,
    MODE_CLOSE    = 3'd3,
    MODE_SKIP     = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    ERR_NONE         = 3'd0,
    ERR_EMPTY        = 3'd1,
    ERR_MISMATCH     = 3'd2,
    ERR_OVERFLOW     = 3'd3,
    ERR_UNCLOSED     = 3'd4,
    ERR_UNTERMINATED = 3'd5,
    ERR_TOO_LONG     = 3'd6
  } err_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic       valid_res;
    logic [2:0] error_code;
  } out_item_t;

  // One stack entry: tag text (character k in bits 8k+7..8k) and its length.
  typedef struct packed {
    logic [NAME_W-1:0] name;
    logic [LEN_W-1:0]  len;
  } entry_t;

  // Stack command broadcast to every cell of the chain.
  typedef struct packed {
    logic push;
    logic pop;
  } stack_op_t;

endpackage

// File: rtl/tag_nesting_checker.sv
// Tag nesting checker: one character per cycle while the input is not stalled; results go to a result buffer.
// Throughput: one character per clock unless the input stalls; the stack is a chain of cells that all shift together.
// The result of a text is registered in the output register, or in the skid register while that one is occupied.
// Input stalls only while both places of the result buffer are full.
// Reset clears parser state, stack depth and result buffer; stack cells are not cleared.
// After each result all parser state returns to its reset value for the next text.
module tag_nesting_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tnc_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tnc_pkg::out_item_t out_data_o
);
  import tnc_pkg::*;

  logic      in_fire;
  logic      buf_full;
  logic      res_valid;
  out_item_t res;
  stack_op_t stack_op;
  entry_t    push_entry;
  entry_t    cell_entry [STACK_DEPTH];

  assign in_stall_o = buf_full;
  assign in_fire    = in_valid_i && !buf_full;

  // Parser and stack control.
  tnc_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (in_fire),
    .item_i       (in_data_i),
    .top_i        (cell_entry[0]),
    .op_o         (stack_op),
    .push_entry_o (push_entry),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // Stack as a chain of cells; cell 0 is the top entry.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_top
      tnc_cell u_cell (
        .clk_i        (clk_i),
        .op_i         (stack_op),
        .from_above_i (push_entry),
        .from_below_i (cell_entry[(STACK_DEPTH > 1) ? 1 : 0]),
        .entry_o      (cell_entry[i])
      );
    end else if (i == STACK_DEPTH - 1) begin : g_bottom
      tnc_cell u_cell (
        .clk_i        (clk_i),
        .op_i         (stack_op),
        .from_above_i (cell_entry[i-1]),
        .from_below_i (cell_entry[i]),
        .entry_o      (cell_entry[i])
      );
    end else begin : g_mid
      tnc_cell u_cell (
        .clk_i        (clk_i),
        .op_i         (stack_op),
        .from_above_i (cell_entry[i-1]),
        .from_below_i (cell_entry[i+1]),
        .entry_o      (cell_entry[i])
      );
    end
  end

  // Result buffer toward the output channel.
  tnc_result_buf u_result_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .data_i      (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef NO_ASSERTIONS
  // The skid place is only used while the output register is occupied.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o) else $error("skid full with empty output register");

  // The stack never pushes and pops in the same cycle.
  a_op_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(stack_op.push && stack_op.pop)) else $error("push and pop together");

  // Stack commands come only from accepted characters.
  a_op_on_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stack_op.push || stack_op.pop) |-> in_fire) else $error("stack command without transaction");

  // The valid flag of a result agrees with its error code.
  a_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.valid_res == (out_data_o.error_code == ERR_NONE)))
    else $error("valid flag disagrees with error code");
`endif

endmodule

// File: rtl/tnc_cell.sv
// One stack cell: holds one entry and shifts with its neighbors on push and pop.
module tnc_cell (
  input  logic               clk_i,
  input  tnc_pkg::stack_op_t op_i,
  input  tnc_pkg::entry_t    from_above_i,
  input  tnc_pkg::entry_t    from_below_i,
  output tnc_pkg::entry_t    entry_o
);
  import tnc_pkg::*;

  entry_t entry_q;

  // A push moves entries one place deeper, a pop one place toward the top.
  always_ff @(posedge clk_i) begin
    if (op_i.push) begin
      entry_q <= from_above_i;
    end else if (op_i.pop) begin
      entry_q <= from_below_i;
    end
  end

  assign entry_o = entry_q;

endmodule

// File: rtl/tnc_parser.sv
// Character parser: tag state machine, name gathering, stack control and error tracking.
module tnc_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  tnc_pkg::in_item_t   item_i,
  input  tnc_pkg::entry_t     top_i,
  output tnc_pkg::stack_op_t  op_o,
  output tnc_pkg::entry_t     push_entry_o,
  output logic                res_valid_o,
  output tnc_pkg::out_item_t  res_o
);
  import tnc_pkg::*;

  mode_e              mode_q, mode_d, mode_step;
  err_e               err_q, err_d, err_step, err_next;
  logic [NAME_W-1:0]  buf_q, buf_d, buf_step;
  logic [LEN_W-1:0]   len_q, len_d, len_step;
  logic [DEPTH_W-1:0] depth_q, depth_d, depth_next;

  logic [7:0]         c;
  logic               active;
  logic               is_gt;
  logic [NAME_W-1:0]  eff_buf;
  logic [LEN_W-1:0]   eff_len;
  logic               can_append;
  logic [NAME_W-1:0]  app_buf;
  logic [LEN_W-1:0]   app_len;
  logic               is_img;
  logic [NAME_W-1:0]  cmp_mask;
  logic               top_match;
  logic               stack_empty;
  logic               stack_full;
  logic               push_step;
  logic               pop_step;
  stack_op_t          op;
  err_e               code;

  assign c           = item_i.ch;
  assign is_gt       = (c == CH_GT);
  assign active      = fire_i && (err_q == ERR_NONE);
  assign stack_empty = (depth_q == '0);
  assign stack_full  = (depth_q == DEPTH_W'(STACK_DEPTH));

  // The first character after '<' starts from an empty name.
  assign eff_buf    = (mode_q == MODE_AFTER_LT) ? '0 : buf_q;
  assign eff_len    = (mode_q == MODE_AFTER_LT) ? '0 : len_q;
  assign can_append = (eff_len < LEN_W'(MAX_NAME_CHARS));
  assign app_len    = eff_len + LEN_W'(1);

  // Name with the current character placed at the next free byte.
  always_comb begin
    app_buf = eff_buf;
    for (int k = 0; k < MAX_NAME_CHARS; k++) begin
      if (LEN_W'(k) == eff_len) begin
        app_buf[8*k +: 8] = c;
      end
    end
  end

  // An opening tag becomes self-closing once its first three characters read "img".
  assign is_img = (eff_len == LEN_W'(2)) && (eff_buf[7:0] == CH_I) &&
                  (eff_buf[15:8] == CH_M) && (c == CH_G);

  // A close name matches when it equals the same-length prefix of the top entry.
  always_comb begin
    cmp_mask = '0;
    for (int k = 0; k < MAX_NAME_CHARS; k++) begin
      if (LEN_W'(k) < len_q) begin
        cmp_mask[8*k +: 8] = 8'hFF;
      end
    end
  end

  assign top_match = (len_q <= top_i.len) && (((top_i.name ^ buf_q) & cmp_mask) == '0);

  // Next parse mode for one character.
  always_comb begin
    mode_step = mode_q;
    unique case (mode_q)
      MODE_OUTSIDE: begin
        if (c == CH_LT) begin
          mode_step = MODE_AFTER_LT;
        end
      end
      MODE_AFTER_LT, MODE_OPEN: begin
        if ((mode_q == MODE_AFTER_LT) && (c == CH_SLASH)) begin
          mode_step = MODE_CLOSE;
        end else if (is_gt) begin
          mode_step = MODE_OUTSIDE;
        end else if (is_img) begin
          mode_step = MODE_SKIP;
        end else begin
          mode_step = MODE_OPEN;
        end
      end
      MODE_CLOSE, MODE_SKIP: begin
        if (is_gt) begin
          mode_step = MODE_OUTSIDE;
        end
      end
      default: mode_step = MODE_OUTSIDE;
    endcase
  end

  // Name gathering, stack commands and error detection for one character.
  always_comb begin
    buf_step  = buf_q;
    len_step  = len_q;
    err_step  = ERR_NONE;
    push_step = 1'b0;
    pop_step  = 1'b0;
    unique case (mode_q)
      MODE_AFTER_LT, MODE_OPEN: begin
        buf_step = eff_buf;
        len_step = eff_len;
        if ((mode_q == MODE_AFTER_LT) && (c == CH_SLASH)) begin
          buf_step = '0;
        end else if (is_gt) begin
          if (stack_full) begin
            err_step = ERR_OVERFLOW;
          end else begin
            push_step = 1'b1;
          end
        end else if (can_append) begin
          buf_step = app_buf;
          len_step = app_len;
        end else begin
          err_step = ERR_TOO_LONG;
        end
      end
      MODE_CLOSE: begin
        if (!is_gt) begin
          if (can_append) begin
            buf_step = app_buf;
            len_step = app_len;
          end else begin
            err_step = ERR_TOO_LONG;
          end
        end else if (stack_empty) begin
          err_step = ERR_EMPTY;
        end else if (top_match) begin
          pop_step = 1'b1;
        end else begin
          err_step = ERR_MISMATCH;
        end
      end
      default: begin
      end
    endcase
  end

  // Stack commands only for characters that are processed.
  assign op.push      = active && push_step;
  assign op.pop       = active && pop_step;
  assign op_o         = op;
  assign push_entry_o = '{name: eff_buf, len: eff_len};

  assign err_next   = (err_q != ERR_NONE) ? err_q : (active ? err_step : ERR_NONE);
  assign depth_next = depth_q + DEPTH_W'(op.push) - DEPTH_W'(op.pop);

  // End-of-text verdict from the state after the last character.
  always_comb begin
    priority if (err_next != ERR_NONE) begin
      code = err_next;
    end else if (active && (mode_step != MODE_OUTSIDE)) begin
      code = ERR_UNTERMINATED;
    end else if (!active && (mode_q != MODE_OUTSIDE)) begin
      code = ERR_UNTERMINATED;
    end else if (depth_next != '0) begin
      code = ERR_UNCLOSED;
    end else begin
      code = ERR_NONE;
    end
  end

  assign res_valid_o     = fire_i && item_i.last;
  assign res_o.valid_res = (code == ERR_NONE);
  assign res_o.error_code = code;

  // State update; the last character returns everything to its reset value.
  always_comb begin
    mode_d  = mode_q;
    buf_d   = buf_q;
    len_d   = len_q;
    depth_d = depth_q;
    err_d   = err_next;
    if (active) begin
      mode_d  = mode_step;
      buf_d   = buf_step;
      len_d   = len_step;
      depth_d = depth_next;
    end
    if (fire_i && item_i.last) begin
      mode_d  = MODE_OUTSIDE;
      buf_d   = '0;
      len_d   = '0;
      depth_d = '0;
      err_d   = ERR_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_OUTSIDE;
      err_q   <= ERR_NONE;
      buf_q   <= '0;
      len_q   <= '0;
      depth_q <= '0;
    end else begin
      mode_q  <= mode_d;
      err_q   <= err_d;
      buf_q   <= buf_d;
      len_q   <= len_d;
      depth_q <= depth_d;
    end
  end

endmodule

// File: rtl/tnc_result_buf.sv
// Two-place result buffer: output register plus a skid register.
module tnc_result_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  tnc_pkg::out_item_t data_i,
  output logic               full_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tnc_pkg::out_item_t out_data_o
);
  import tnc_pkg::*;

  logic      out_valid_q, out_valid_d;
  logic      skid_valid_q, skid_valid_d;
  out_item_t out_data_q, out_data_d;
  out_item_t skid_data_q, skid_data_d;
  logic      out_fire;

  assign out_fire = out_valid_q && !out_stall_i;

  // A new result goes to the output register when it frees up, else to the skid.
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      if (out_fire) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || out_fire) begin
        out_data_d  = data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_data_d  = data_i;
        skid_valid_d = 1'b1;
      end
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
